### rtl/wts_pkg.sv
// Shared constants, codes and types of the waypoint target selector.
package wts_pkg;

    localparam int WTS_MAX_WAYPOINTS = 256;

    localparam int COORD_W   = 24;
    localparam int MAG_W     = COORD_W + 1;
    localparam int DIST_W    = 2 * MAG_W;
    localparam int RADIUS_W  = 16;
    localparam int RADIUS2_W = 2 * RADIUS_W;
    localparam int IDX_OUT_W = 8;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam logic [RADIUS_W-1:0] WP_RADIUS_RST   = 16'd500;
    localparam logic [RADIUS_W-1:0] LOOKAHEAD_RST   = 16'd1000;
    localparam logic [RADIUS_W-1:0] GOAL_RADIUS_RST = 16'd300;
    localparam logic [RADIUS_W-1:0] GOAL_RADIUS_MIN = 16'd10;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_WP_RADIUS   = 2'd0;
    localparam logic [1:0] REG_LOOKAHEAD   = 2'd1;
    localparam logic [1:0] REG_GOAL_RADIUS = 2'd2;

    localparam logic [1:0] MODE_POSE  = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] STATUS_NO_PATH = 2'd0;
    localparam logic [1:0] STATUS_TRACK   = 2'd1;
    localparam logic [1:0] STATUS_GOAL    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_START,
        ST_SQ_WAIT,
        ST_RD,
        ST_LAT,
        ST_DWAIT,
        ST_FETCH,
        ST_OUT
    } wts_state_t;

    typedef enum logic [1:0] {
        PH_GOAL,
        PH_NEAR,
        PH_SKIP,
        PH_LOOK
    } wts_phase_t;

    typedef enum logic [1:0] {
        SQ_GOAL,
        SQ_WP,
        SQ_LOOK
    } wts_sq_sel_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_SQX,
        DS_SQY,
        DS_SUM
    } wts_dstep_t;

    // request to the squared-distance unit
    typedef struct packed {
        logic                      start;
        logic signed [COORD_W-1:0] pt_x;
        logic signed [COORD_W-1:0] pt_y;
        logic signed [COORD_W-1:0] ref_x;
        logic signed [COORD_W-1:0] ref_y;
    } wts_dist_req_t;

endpackage

### rtl/wts_dist_unit.sv
// Shared squared-distance unit: one multiplier used for dx^2, then dy^2, then summed.
module wts_dist_unit
    import wts_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  wts_dist_req_t     req,
    output logic              done,
    output logic [DIST_W-1:0] sq_dist
);

    wts_dstep_t               step_reg, step_next;
    logic                     done_reg;
    logic signed [MAG_W-1:0]  dx_reg, dy_reg;
    logic [MAG_W-1:0]         ax, ay, mul_op;
    logic [DIST_W-1:0]        mul_res;
    logic [DIST_W-1:0]        sqx_reg, sqy_reg, dist_reg;

    assign ax      = dx_reg[MAG_W-1] ? MAG_W'(~dx_reg + 1'b1) : MAG_W'(dx_reg);
    assign ay      = dy_reg[MAG_W-1] ? MAG_W'(~dy_reg + 1'b1) : MAG_W'(dy_reg);
    assign mul_op  = (step_reg == DS_SQX) ? ax : ay;
    assign mul_res = DIST_W'(mul_op) * DIST_W'(mul_op);

    always_comb begin
        step_next = step_reg;
        case (step_reg)
            DS_IDLE: if (req.start) step_next = DS_SQX;
            DS_SQX:  step_next = DS_SQY;
            DS_SQY:  step_next = DS_SUM;
            DS_SUM:  step_next = DS_IDLE;
            default: step_next = DS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= DS_IDLE;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            done_reg <= (step_reg == DS_SUM);
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && step_reg == DS_IDLE) begin
            dx_reg <= {req.pt_x[COORD_W-1], req.pt_x} - {req.ref_x[COORD_W-1], req.ref_x};
            dy_reg <= {req.pt_y[COORD_W-1], req.pt_y} - {req.ref_y[COORD_W-1], req.ref_y};
        end
        if (step_reg == DS_SQX) sqx_reg <= mul_res;
        if (step_reg == DS_SQY) sqy_reg <= mul_res;
        if (step_reg == DS_SUM) dist_reg <= sqx_reg + sqy_reg;
    end

    assign done    = done_reg;
    assign sq_dist = dist_reg;

endmodule

### rtl/wts_wp_mem.sv
// Waypoint store: one write port, one registered read port, x and y side by side.
module wts_wp_mem
    import wts_pkg::*;
#(
    parameter int DEPTH = WTS_MAX_WAYPOINTS
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH)-1:0]         wr_addr,
    input  logic signed [COORD_W-1:0]        wr_x,
    input  logic signed [COORD_W-1:0]        wr_y,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         rd_addr,
    output logic signed [COORD_W-1:0]        rd_x,
    output logic signed [COORD_W-1:0]        rd_y
);

    logic [2*COORD_W-1:0] mem [DEPTH];
    logic [2*COORD_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= {wr_x, wr_y};
        if (rd_en) rdata_reg <= mem[rd_addr];
    end

    assign rd_x = rdata_reg[2*COORD_W-1:COORD_W];
    assign rd_y = rdata_reg[COORD_W-1:0];

endmodule

### rtl/waypoint_target_selector.sv
// Top level of the waypoint target selector: APB registers, sequencer, store and distance unit.
//
// Usage: items arrive on the s_ channel (valid/ready). mode 1 appends a waypoint
// (first_point = 1 restarts the path), mode 2 clears the path; both give no
// result. mode 0 is a pose query and gives exactly one m_ transaction:
// status 0 (no path), 1 (tracking, with target index and coordinates) or 2 (goal).
// Three 16-bit radius registers sit on the APB port at byte addresses 0, 4 and 8.
// Search: a query walks the waypoint store through one shared squared-distance
// unit with a single 25x25 multiplier; each waypoint visited takes a store read,
// a launch, three multiply/add steps and a decision, and each squared radius
// takes a launch and the same three steps. A query visits the last waypoint,
// then those from the cursor to the end, then those in the skip and lookahead walks.
// s_ready is low for the whole query. Reset (aresetn low, synchronous) empties the
// path, zeroes the cursor and loads the radius reset values; store contents are not
// cleared, only entries below the path length are ever read. A result waits in the
// output register while m_ready is low; loads and clears keep flowing meanwhile, and
// the next query finishes its search but holds its result until the register frees.
module waypoint_target_selector
    import wts_pkg::*;
#(
    parameter int MAX_WAYPOINTS = WTS_MAX_WAYPOINTS
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [APB_ADDR_W-1:0]       paddr,
    input  logic [APB_DATA_W-1:0]       pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready,
    // input items
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_mode,
    input  logic signed [COORD_W-1:0]   s_pos_x,
    input  logic signed [COORD_W-1:0]   s_pos_y,
    input  logic                        s_first_point,
    // results
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_status,
    output logic [IDX_OUT_W-1:0]        m_target_idx,
    output logic signed [COORD_W-1:0]   m_target_x,
    output logic signed [COORD_W-1:0]   m_target_y
);

    localparam int AW = $clog2(MAX_WAYPOINTS);
    localparam int LW = $clog2(MAX_WAYPOINTS + 1);
    localparam int EW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

    // configuration registers
    logic [RADIUS_W-1:0] wp_radius_reg, lookahead_reg, goal_radius_reg;
    logic [RADIUS_W-1:0] gr_eff, thr_sel;
    logic                apb_wr;

    // sequencer state
    wts_state_t          state_reg, state_next;
    wts_phase_t          phase_reg, phase_next;
    wts_sq_sel_t         sq_sel_reg, sq_sel_next;
    logic [LW-1:0]       len_reg, len_next, len_m1;
    logic [AW-1:0]       cursor_reg, cursor_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [AW-1:0]       best_reg, best_next;
    logic [AW-1:0]       start_reg, start_next;
    logic [AW-1:0]       tgt_reg, tgt_next;
    logic [AW-1:0]       last, start_pos;
    logic [DIST_W-1:0]   best_d_reg, best_d_next;
    logic [RADIUS2_W-1:0] gr2_reg, gr2_next, wr2_reg, wr2_next, la2_reg, la2_next;
    logic [1:0]          status_reg, status_next;
    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic                s_accept;

    // output register
    logic                m_valid_reg, out_load;
    logic [1:0]          m_status_reg;
    logic [IDX_OUT_W-1:0] m_index_reg;
    logic signed [COORD_W-1:0] m_x_reg, m_y_reg;
    logic [EW-1:0]       tgt_ext;

    // store and distance unit
    logic                wr_en, rd_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic signed [COORD_W-1:0] rd_x, rd_y;
    wts_dist_req_t       dreq;
    logic                dist_done;
    logic [DIST_W-1:0]   sq_dist;

    // ---------------- APB ----------------
    assign pready = 1'b1;
    assign apb_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[3:2])
            REG_WP_RADIUS:   prdata = APB_DATA_W'(wp_radius_reg);
            REG_LOOKAHEAD:   prdata = APB_DATA_W'(lookahead_reg);
            REG_GOAL_RADIUS: prdata = APB_DATA_W'(goal_radius_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_radius_reg   <= WP_RADIUS_RST;
            lookahead_reg   <= LOOKAHEAD_RST;
            goal_radius_reg <= GOAL_RADIUS_RST;
        end else if (apb_wr) begin
            case (paddr[3:2])
                REG_WP_RADIUS:   wp_radius_reg   <= pwdata[RADIUS_W-1:0];
                REG_LOOKAHEAD:   lookahead_reg   <= pwdata[RADIUS_W-1:0];
                REG_GOAL_RADIUS: goal_radius_reg <= pwdata[RADIUS_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- datapath helpers ----------------
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign len_m1    = len_reg - 1'b1;
    assign last      = len_m1[AW-1:0];
    assign start_pos = (cursor_reg < last) ? cursor_reg : last;
    // goal radius is floored at its minimum
    assign gr_eff    = (goal_radius_reg < GOAL_RADIUS_MIN) ? GOAL_RADIUS_MIN : goal_radius_reg;

    always_comb begin
        case (sq_sel_reg)
            SQ_GOAL: thr_sel = gr_eff;
            SQ_WP:   thr_sel = wp_radius_reg;
            SQ_LOOK: thr_sel = lookahead_reg;
            default: thr_sel = '0;
        endcase
    end

    // radius squares reuse the distance unit: point (r, 0) against the origin
    always_comb begin
        dreq.start = (state_reg == ST_SQ_START) || (state_reg == ST_LAT);
        if (state_reg == ST_SQ_START) begin
            dreq.pt_x  = {{(COORD_W-RADIUS_W){1'b0}}, thr_sel};
            dreq.pt_y  = '0;
            dreq.ref_x = '0;
            dreq.ref_y = '0;
        end else begin
            dreq.pt_x  = rd_x;
            dreq.pt_y  = rd_y;
            dreq.ref_x = px_reg;
            dreq.ref_y = py_reg;
        end
    end

    // store ports: writes only while idle, reads only during a query
    assign wr_en   = s_accept && (s_mode == MODE_LOAD) &&
                     (s_first_point || (len_reg < LW'(MAX_WAYPOINTS)));
    assign wr_addr = s_first_point ? '0 : len_reg[AW-1:0];
    assign rd_en   = (state_reg == ST_RD) || (state_reg == ST_FETCH);
    assign rd_addr = (state_reg == ST_FETCH) ? tgt_reg : idx_reg;

    // ---------------- sequencer ----------------
    always_comb begin
        logic [AW-1:0]     nb;
        logic [DIST_W-1:0] nbd;

        nb          = best_reg;
        nbd         = best_d_reg;
        state_next  = state_reg;
        phase_next  = phase_reg;
        sq_sel_next = sq_sel_reg;
        len_next    = len_reg;
        cursor_next = cursor_reg;
        idx_next    = idx_reg;
        best_next   = best_reg;
        best_d_next = best_d_reg;
        start_next  = start_reg;
        tgt_next    = tgt_reg;
        gr2_next    = gr2_reg;
        wr2_next    = wr2_reg;
        la2_next    = la2_reg;
        status_next = status_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_LOAD: begin
                            if (s_first_point) begin
                                len_next    = LW'(1);
                                cursor_next = '0;
                            end else if (len_reg < LW'(MAX_WAYPOINTS)) begin
                                len_next = len_reg + 1'b1;
                            end
                        end
                        MODE_CLEAR: begin
                            len_next    = '0;
                            cursor_next = '0;
                        end
                        MODE_POSE: begin
                            if (len_reg == '0) begin
                                status_next = STATUS_NO_PATH;
                                state_next  = ST_OUT;
                            end else begin
                                sq_sel_next = SQ_GOAL;
                                state_next  = ST_SQ_START;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SQ_START: state_next = ST_SQ_WAIT;
            ST_SQ_WAIT: begin
                if (dist_done) begin
                    case (sq_sel_reg)
                        SQ_GOAL: begin
                            gr2_next   = sq_dist[RADIUS2_W-1:0];
                            idx_next   = last;
                            phase_next = PH_GOAL;
                            state_next = ST_RD;
                        end
                        SQ_WP: begin
                            wr2_next    = sq_dist[RADIUS2_W-1:0];
                            sq_sel_next = SQ_LOOK;
                            state_next  = ST_SQ_START;
                        end
                        SQ_LOOK: begin
                            la2_next   = sq_dist[RADIUS2_W-1:0];
                            idx_next   = start_pos;
                            start_next = start_pos;
                            phase_next = PH_NEAR;
                            state_next = ST_RD;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RD:  state_next = ST_LAT;
            ST_LAT: state_next = ST_DWAIT;
            ST_DWAIT: begin
                if (dist_done) begin
                    case (phase_reg)
                        PH_GOAL: begin
                            if (sq_dist <= DIST_W'(gr2_reg)) begin
                                // goal: store data already holds the last waypoint
                                status_next = STATUS_GOAL;
                                tgt_next    = last;
                                state_next  = ST_OUT;
                            end else begin
                                sq_sel_next = SQ_WP;
                                state_next  = ST_SQ_START;
                            end
                        end
                        PH_NEAR: begin
                            // strict less-than keeps the first of equal distances
                            if (idx_reg == start_reg || sq_dist < best_d_reg) begin
                                nb  = idx_reg;
                                nbd = sq_dist;
                            end
                            best_next   = nb;
                            best_d_next = nbd;
                            if (idx_reg == last) begin
                                idx_next   = nb;
                                phase_next = PH_SKIP;
                            end else begin
                                idx_next = idx_reg + 1'b1;
                            end
                            state_next = ST_RD;
                        end
                        default: begin
                            if (phase_reg == PH_SKIP && idx_reg != last &&
                                sq_dist < DIST_W'(wr2_reg)) begin
                                idx_next   = idx_reg + 1'b1;
                                state_next = ST_RD;
                            end else if (sq_dist >= DIST_W'(la2_reg) || idx_reg == last) begin
                                status_next = STATUS_TRACK;
                                tgt_next    = idx_reg;
                                cursor_next = idx_reg;
                                state_next  = ST_FETCH;
                            end else begin
                                idx_next   = idx_reg + 1'b1;
                                phase_next = PH_LOOK;
                                state_next = ST_RD;
                            end
                        end
                    endcase
                end
            end
            ST_FETCH: state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_GOAL;
            sq_sel_reg <= SQ_GOAL;
            len_reg    <= '0;
            cursor_reg <= '0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            sq_sel_reg <= sq_sel_next;
            len_reg    <= len_next;
            cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        best_reg   <= best_next;
        best_d_reg <= best_d_next;
        start_reg  <= start_next;
        tgt_reg    <= tgt_next;
        gr2_reg    <= gr2_next;
        wr2_reg    <= wr2_next;
        la2_reg    <= la2_next;
        status_reg <= status_next;
        if (s_accept && s_mode == MODE_POSE) begin
            px_reg <= s_pos_x;
            py_reg <= s_pos_y;
        end
    end

    // ---------------- output register ----------------
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign tgt_ext  = EW'(tgt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= status_reg;
            if (status_reg == STATUS_NO_PATH) begin
                m_index_reg <= '0;
                m_x_reg     <= '0;
                m_y_reg     <= '0;
            end else begin
                m_index_reg <= tgt_ext[IDX_OUT_W-1:0];
                m_x_reg     <= rd_x;
                m_y_reg     <= rd_y;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_target_idx = m_index_reg;
    assign m_target_x   = m_x_reg;
    assign m_target_y   = m_y_reg;

    // ---------------- submodules ----------------
    wts_wp_mem #(
        .DEPTH(MAX_WAYPOINTS)
    ) u_mem (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_x   (s_pos_x),
        .wr_y   (s_pos_y),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_x   (rd_x),
        .rd_y   (rd_y)
    );

    wts_dist_unit u_dist (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (dreq),
        .done   (dist_done),
        .sq_dist(sq_dist)
    );

    // ---------------- assertions ----------------
    // cursor always points inside the path, or both are zero
    a_cursor_in_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (LW'(cursor_reg) < len_reg) || (len_reg == '0 && cursor_reg == '0))
        else $error("search cursor outside the stored path");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_WAYPOINTS))
        else $error("path length beyond store depth");

    // a distance result only shows up while the sequencer waits for it
    a_done_expected: assert property (@(posedge aclk) disable iff (!aresetn)
        dist_done |-> (state_reg == ST_DWAIT || state_reg == ST_SQ_WAIT))
        else $error("distance result outside a wait state");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised without a finished query");

endmodule

### sim/tb.sv
// Self-checking testbench of the waypoint target selector: predictor, stimulus and checks.
module tb;
    import wts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The fourth mode code is not in the package; the block must ignore it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 165;
    localparam longint COORD_MAX = 64'sd8388607;
    localparam longint COORD_MIN = -64'sd8388608;

    typedef struct packed {
        logic [1:0]                status;
        logic [IDX_OUT_W-1:0]      index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } target_t;

    // Holds its own copy of the path, cursor and radius registers, and the
    // queue of target transactions the block still owes.
    class target_board;
        logic signed [COORD_W-1:0] wp_x [WTS_MAX_WAYPOINTS];
        logic signed [COORD_W-1:0] wp_y [WTS_MAX_WAYPOINTS];
        int unsigned               path_len;
        int unsigned               cursor;
        logic [RADIUS_W-1:0]       wp_radius;
        logic [RADIUS_W-1:0]       lookahead;
        logic [RADIUS_W-1:0]       goal_radius;
        target_t                   pending_targets[$];
        int                        errors;
        int                        checked;

        function void reset_state();
            path_len    = 0;
            cursor      = 0;
            wp_radius   = WP_RADIUS_RST;
            lookahead   = LOOKAHEAD_RST;
            goal_radius = GOAL_RADIUS_RST;
        endfunction

        function void write_reg(logic [1:0] idx, logic [RADIUS_W-1:0] value);
            case (idx)
                REG_WP_RADIUS:   wp_radius = value;
                REG_LOOKAHEAD:   lookahead = value;
                REG_GOAL_RADIUS: goal_radius = value;
                default: ;
            endcase
        endfunction

        // exact squared distance, up to 2^49
        function logic [63:0] dist_sq(int unsigned i, logic signed [COORD_W-1:0] px,
                                      logic signed [COORD_W-1:0] py);
            longint dx;
            longint dy;
            dx = longint'(wp_x[i]) - longint'(px);
            dy = longint'(wp_y[i]) - longint'(py);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            return dx * dx + dy * dy;
        endfunction

        // nearest from cursor on, skip passed waypoints, then first one at lookahead
        function int unsigned choose_target(logic signed [COORD_W-1:0] px,
                                            logic signed [COORD_W-1:0] py);
            int unsigned last;
            int unsigned best;
            logic [63:0] best_d;
            logic [63:0] d;
            logic [63:0] wr2;
            logic [63:0] la2;
            last   = path_len - 1;
            best   = (cursor < last) ? cursor : last;
            best_d = dist_sq(best, px, py);
            wr2    = 64'(wp_radius) * 64'(wp_radius);
            la2    = 64'(lookahead) * 64'(lookahead);
            for (int unsigned i = best + 1; i < path_len; i++) begin
                d = dist_sq(i, px, py);
                if (d < best_d) begin
                    best   = i;
                    best_d = d;
                end
            end
            while (best < last && dist_sq(best, px, py) < wr2)
                best++;
            for (int unsigned i = best; i < path_len; i++) begin
                if (dist_sq(i, px, py) >= la2)
                    return i;
            end
            return last;
        endfunction

        function void note_item(logic [1:0] mode, logic signed [COORD_W-1:0] px,
                                logic signed [COORD_W-1:0] py, logic first);
            target_t             t;
            int unsigned         last;
            int unsigned         idx;
            logic [RADIUS_W-1:0] gr;
            t = '0;
            case (mode)
                MODE_LOAD: begin
                    if (first) begin
                        path_len = 0;
                        cursor   = 0;
                    end
                    if (path_len < WTS_MAX_WAYPOINTS) begin
                        wp_x[path_len] = px;
                        wp_y[path_len] = py;
                        path_len++;
                    end
                end
                MODE_CLEAR: begin
                    path_len = 0;
                    cursor   = 0;
                end
                MODE_POSE: begin
                    if (path_len == 0) begin
                        t.status = STATUS_NO_PATH;
                    end else begin
                        last = path_len - 1;
                        gr   = (goal_radius < GOAL_RADIUS_MIN) ? GOAL_RADIUS_MIN : goal_radius;
                        if (dist_sq(last, px, py) <= 64'(gr) * 64'(gr)) begin
                            idx      = last;
                            t.status = STATUS_GOAL;
                        end else begin
                            idx      = choose_target(px, py);
                            cursor   = idx;
                            t.status = STATUS_TRACK;
                        end
                        t.index = idx[IDX_OUT_W-1:0];
                        t.x     = wp_x[idx];
                        t.y     = wp_y[idx];
                    end
                    pending_targets = {pending_targets, t};
                end
                default: ;
            endcase
        endfunction

        function void check_target(target_t got);
            target_t want;
            if (pending_targets.size() == 0) begin
                $display("%0t: unexpected target transaction, actual status %0d index %0d",
                         $time, got.status, got.index);
                errors++;
                return;
            end
            want = pending_targets.pop_front();
            checked++;
            if (got.status !== want.status) begin
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, want.status, got.status);
                errors++;
            end
            if (got.index !== want.index) begin
                $display("%0t: target index mismatch, expected %0d, actual %0d",
                         $time, want.index, got.index);
                errors++;
            end
            if (got.x !== want.x) begin
                $display("%0t: target_x mismatch, expected %0d, actual %0d",
                         $time, want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $display("%0t: target_y mismatch, expected %0d, actual %0d",
                         $time, want.y, got.y);
                errors++;
            end
        endfunction
    endclass

    bit                        aclk;
    logic                      aresetn;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;
    logic                      s_valid;
    logic                      s_ready;
    logic [1:0]                s_mode;
    logic signed [COORD_W-1:0] s_pos_x;
    logic signed [COORD_W-1:0] s_pos_y;
    logic                      s_first_point;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic [1:0]                m_status;
    logic [IDX_OUT_W-1:0]      m_target_idx;
    logic signed [COORD_W-1:0] m_target_x;
    logic signed [COORD_W-1:0] m_target_y;

    target_board board;
    bit          calm;         // last phase: no idling on either side
    int          s_odds;       // 1-in-N chance of a sender gap, 0 = none
    int          m_odds;       // 1-in-N chance of a receiver stall, 0 = none
    int          stall_left = 0;
    int          items_sent;   // accepted transactions, ignored mode not counted

    waypoint_target_selector uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_pos_x        (s_pos_x),
        .s_pos_y        (s_pos_y),
        .s_first_point  (s_first_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_target_idx   (m_target_idx),
        .m_target_x     (m_target_x),
        .m_target_y     (m_target_y)
    );

    // 4 ns period; bit type so there is no x->0 edge at time zero
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Receiver side: random stall bursts, driven at the falling edge.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!calm && m_odds != 0 && $urandom_range(0, m_odds - 1) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result monitor: every accepted target transaction goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_target('{m_status, m_target_idx, m_target_x, m_target_y});
    end

    function automatic logic signed [COORD_W-1:0] clamp24(longint v);
        if (v > COORD_MAX) return COORD_W'(COORD_MAX);
        if (v < COORD_MIN) return COORD_W'(COORD_MIN);
        return COORD_W'(v);
    endfunction

    function automatic longint jitter(int span);
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Present one transaction on the s_ channel. Called just after a falling
    // edge; returns just after the falling edge that follows acceptance.
    task automatic offer_item(logic [1:0] mode, logic signed [COORD_W-1:0] px,
                              logic signed [COORD_W-1:0] py, logic first);
        if (!calm && s_odds != 0 && $urandom_range(0, s_odds - 1) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_pos_x       <= px;
        s_pos_y       <= py;
        s_first_point <= first;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        board.note_item(mode, px, py, first);
        if (mode != MODE_UNUSED)
            items_sent++;
        @(negedge aclk);
    endtask

    // APB write in setup + access, then read the register back.
    task automatic apb_write(logic [1:0] idx, logic [RADIUS_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.write_reg(idx, value);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[RADIUS_W-1:0] !== value) begin
            $display("%0t: register %0d readback mismatch, expected %0d, actual %0d",
                     $time, idx, value, prdata[RADIUS_W-1:0]);
            board.errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Block is idle once nothing is owed and any load or clear in flight has
    // been taken, so give it a short margin before touching registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (board.pending_targets.size() != 0)
            @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // Extremes of the fields, every mode, empty path, goal boundary, ties.
    // Runs with the reset radii: passed 500, lookahead 1000, goal 300.
    task automatic run_directed();
        offer_item(MODE_POSE, 24'sd0, 24'sd0, 1'b0);                  // no path
        offer_item(MODE_CLEAR, 24'sd0, 24'sd0, 1'b0);
        offer_item(MODE_UNUSED, -24'sd1, -24'sd1, 1'b1);              // ignored
        offer_item(MODE_POSE, clamp24(COORD_MIN), clamp24(COORD_MAX), 1'b1);
        offer_item(MODE_LOAD, clamp24(COORD_MAX), clamp24(COORD_MIN), 1'b1);
        offer_item(MODE_LOAD, clamp24(COORD_MIN), clamp24(COORD_MAX), 1'b0);
        offer_item(MODE_LOAD, 24'sd0, 24'sd0, 1'b0);
        offer_item(MODE_POSE, 24'sd0, 24'sd0, 1'b0);                  // goal
        offer_item(MODE_POSE, clamp24(COORD_MAX), clamp24(COORD_MAX), 1'b0);
        offer_item(MODE_POSE, clamp24(COORD_MIN), clamp24(COORD_MIN), 1'b0);
        // new path with a duplicated first point: nearest search keeps the first
        offer_item(MODE_LOAD, 24'sd0, 24'sd0, 1'b1);
        offer_item(MODE_LOAD, 24'sd0, 24'sd0, 1'b0);
        offer_item(MODE_LOAD, 24'sd2000, 24'sd0, 1'b0);
        offer_item(MODE_LOAD, 24'sd4000, 24'sd0, 1'b0);
        offer_item(MODE_POSE, 24'sd0, 24'sd100, 1'b0);
        offer_item(MODE_POSE, 24'sd3000, 24'sd0, 1'b1);
        // goal radius boundary: inside, exactly on, just outside
        offer_item(MODE_POSE, 24'sd4000, 24'sd299, 1'b0);
        offer_item(MODE_POSE, 24'sd4000, 24'sd300, 1'b0);
        offer_item(MODE_POSE, 24'sd4000, 24'sd301, 1'b0);
        offer_item(MODE_POSE, -24'sd4000, 24'sd0, 1'b0);              // behind the cursor
        offer_item(MODE_CLEAR, 24'sd5, -24'sd5, 1'b1);
        offer_item(MODE_POSE, 24'sd4000, 24'sd0, 1'b0);               // no path again
        offer_item(MODE_UNUSED, clamp24(COORD_MAX), clamp24(COORD_MIN), 1'b0);
    endtask

    // One path: optional clear, loads along a random walk with duplicates and
    // early queries mixed in, then queries that move along the path. Short
    // paths get some noise; a long path fills the store and overflows it.
    task automatic run_path(int scale, bit long_path);
        logic signed [COORD_W-1:0] path_x [300];
        logic signed [COORD_W-1:0] path_y [300];
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        int  n;
        int  m;
        int  q;
        int  k;
        int  span;
        bit  cleared;
        s_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        m_odds  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
        n       = long_path ? WTS_MAX_WAYPOINTS + $urandom_range(1, 3) : $urandom_range(1, 24);
        m       = (n < WTS_MAX_WAYPOINTS) ? n : WTS_MAX_WAYPOINTS;
        cx      = COORD_W'($urandom);
        cy      = COORD_W'($urandom);
        cleared = ($urandom_range(0, 4) == 0);
        if (cleared)
            offer_item(MODE_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
                       1'($urandom_range(0, 1)));
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(0, 9) != 0) begin
                cx = clamp24(longint'(cx) + longint'($urandom_range(0, 2 * scale)) - scale / 2);
                cy = clamp24(longint'(cy) + jitter(scale));
            end
            path_x[i] = cx;
            path_y[i] = cy;
            if (!long_path && $urandom_range(0, 11) == 0)
                offer_item(2'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                           1'($urandom_range(0, 1)));
            offer_item(MODE_LOAD, cx, cy, (i == 0) && !cleared);
            if (i > 0 && $urandom_range(0, 7) == 0)
                offer_item(MODE_POSE, clamp24(longint'(cx) + jitter(scale)),
                           clamp24(longint'(cy) + jitter(scale)), 1'($urandom_range(0, 1)));
        end
        q = long_path ? 8 : $urandom_range(1, 2 * n + 2);
        for (int j = 0; j < q; j++) begin
            k    = (j * m) / q;
            span = ($urandom_range(0, 3) == 0) ? scale / 20 + 1 : scale;
            if ($urandom_range(0, 5) == 0)
                k = m - 1;
            if (!long_path && $urandom_range(0, 11) == 0)
                offer_item(2'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                           1'($urandom_range(0, 1)));
            offer_item(MODE_POSE, clamp24(longint'(path_x[k]) + jitter(span)),
                       clamp24(longint'(path_y[k]) + jitter(span)), 1'($urandom_range(0, 1)));
        end
    endtask

    // Main sequence: reset, directed items, then one random phase per radius
    // setting. Registers change only with the block idle.
    initial begin
        logic [RADIUS_W-1:0] wr;
        logic [RADIUS_W-1:0] la;
        logic [RADIUS_W-1:0] gr;
        int                  scale;
        int                  goal_count;
        bit                  long_next;
        board         = new();
        board.reset_state();
        aresetn       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        s_valid       = 1'b0;
        s_mode        = MODE_POSE;
        s_pos_x       = '0;
        s_pos_y       = '0;
        s_first_point = 1'b0;
        calm          = 1'b0;
        s_odds        = 4;
        m_odds        = 4;
        items_sent    = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                wr = WP_RADIUS_RST;
                la = LOOKAHEAD_RST;
                gr = GOAL_RADIUS_RST;
            end else begin
                wait_idle();
                case (p)
                    1: begin wr = 16'd0;     la = 16'd0;     gr = 16'd0;     end
                    2: begin wr = 16'hFFFF;  la = 16'hFFFF;  gr = 16'hFFFF;  end
                    3: begin wr = 16'd500;   la = 16'd1000;  gr = 16'd9;     end
                    4: begin
                        wr = RADIUS_W'($urandom_range(0, 3000));
                        la = RADIUS_W'($urandom_range(0, 6000));
                        gr = 16'd10;
                    end
                    default: begin
                        wr = RADIUS_W'($urandom_range(0, 20000));
                        la = RADIUS_W'($urandom_range(0, 40000));
                        gr = RADIUS_W'($urandom_range(0, 2000));
                    end
                endcase
                apb_write(REG_WP_RADIUS, wr);
                apb_write(REG_LOOKAHEAD, la);
                apb_write(REG_GOAL_RADIUS, gr);
            end
            calm       = (p == PHASES - 1);
            // step size follows the radii so the distance tests split both ways
            scale      = ((wr > la) ? wr : la) / 2 + $urandom_range(50, 1500);
            goal_count = items_sent + ITEMS_PER_PHASE;
            long_next  = (p == 1);
            while (items_sent < goal_count) begin
                run_path(scale, long_next || (!calm && $urandom_range(0, 39) == 0));
                long_next = 1'b0;
            end
        end

        s_valid <= 1'b0;
        while (board.pending_targets.size() != 0)
            @(negedge aclk);
        repeat (50) @(posedge aclk);

        $display("run: %0d input transactions, %0d target transactions checked",
                 items_sent, board.checked);
        $display("run: %0d radius settings incl. zero and full-scale, full path with overflow",
                 PHASES);
        if (board.errors == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog: a correct run finishes long before this limit, which lies above
    // even a run of nothing but full-path queries.
    initial begin
        #100_000_000;
        $display("timeout waiting for the block");
        $display("FAIL");
        $finish;
    end

endmodule
